### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every rising edge outside reset.
`define SPKD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define SPKD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define SPKD_ASSERT(lbl, clk, rstn, prop, msg)
`define SPKD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

### sv/spkdec_pkg.sv
// Types, constants and helper functions of the Speck 128/128 decryptor.
package spkdec_pkg;

  localparam int unsigned WordW      = 64;
  localparam int unsigned RoundCount = 32;
  localparam int unsigned CntW       = (RoundCount > 1) ? $clog2(RoundCount) : 1;
  localparam int unsigned CfgIdxW    = 8;

  // Rotation amounts of the schedule and of the inverse round
  localparam int unsigned KeyRotL   = 56;
  localparam int unsigned KeyKRotL  = 3;
  localparam int unsigned RndFRotL  = 61;
  localparam int unsigned RndSRotL  = 8;

  typedef logic [WordW-1:0] word_t;
  typedef logic [CntW-1:0]  cnt_t;

  localparam cnt_t CntLast = cnt_t'(RoundCount - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyFirst  = 8'd0,
    CfgKeySecond = 8'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StExpand,
    StPrefetch,
    StRound,
    StFinish
  } state_e;

  typedef struct packed {
    logic load_in;    // capture the input item
    logic kx_start;   // load schedule words, counter to zero
    logic kx_step;    // store one round key, advance schedule
    logic round_step; // one inverse round
    logic load_out;   // move result into output register
  } cmd_t;

  typedef struct packed {
    logic keys_valid;
    logic cnt_last;
    logic cnt_zero;
    logic out_free;
  } status_t;

  function automatic word_t rol(word_t v, int unsigned n);
    return (v << n) | (v >> (WordW - n));
  endfunction

endpackage

### sv/spkdec_in_if.sv
// Ciphertext input channel.
interface spkdec_in_if;
  logic                valid;
  logic                ready;
  spkdec_pkg::word_t   cipher_first;
  spkdec_pkg::word_t   cipher_second;
  logic                last_block;

  modport source (output valid, cipher_first, cipher_second, last_block, input ready);
  modport sink   (input valid, cipher_first, cipher_second, last_block, output ready);
endinterface

### sv/spkdec_out_if.sv
// Plaintext output channel.
interface spkdec_out_if;
  logic                valid;
  logic                ready;
  spkdec_pkg::word_t   plain_first;
  spkdec_pkg::word_t   plain_second;
  logic                last_out;

  modport source (output valid, plain_first, plain_second, last_out, input ready);
  modport sink   (input valid, plain_first, plain_second, last_out, output ready);
endinterface

### sv/spkdec_cfg_if.sv
// Configuration write channel.
interface spkdec_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [spkdec_pkg::CfgIdxW-1:0]       index;
  spkdec_pkg::word_t                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/spkdec_ctrl.sv
// Sequencer of key expansion, decryption rounds and result hand-off.
module spkdec_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spkdec_pkg::status_t status_i,
  output spkdec_pkg::cmd_t    cmd_o
);
  import spkdec_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          if (!status_i.keys_valid) begin
            cmd_o.kx_start = 1'b1;
            state_d        = StExpand;
          end else begin
            state_d = StRound;
          end
        end
      end
      StExpand: begin
        cmd_o.kx_step = 1'b1;
        if (status_i.cnt_last) begin
          state_d = StPrefetch;
        end
      end
      // last key was written this cycle before; fetch it now
      StPrefetch: begin
        state_d = StRound;
      end
      StRound: begin
        cmd_o.round_step = 1'b1;
        if (status_i.cnt_zero) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

### sv/spkdec_dp.sv
// Datapath: key registers, key schedule, round-key memory, inverse round, output register.
module spkdec_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spkdec_pkg::cmd_t                  cmd_i,
  output spkdec_pkg::status_t               status_o,
  input  logic                              cfg_wr_i,
  input  logic [spkdec_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  spkdec_pkg::word_t                 cfg_data_i,
  input  spkdec_pkg::word_t                 cipher_first_i,
  input  spkdec_pkg::word_t                 cipher_second_i,
  input  logic                              last_block_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output spkdec_pkg::word_t                 plain_first_o,
  output spkdec_pkg::word_t                 plain_second_o,
  output logic                              last_out_o
);
  import spkdec_pkg::*;

  word_t key0_q, key1_q;
  logic  keys_valid_q, keys_valid_d;
  cnt_t  cnt_q, cnt_d;
  logic  out_valid_q, out_valid_d;

  word_t k_q, l_q, k_d, l_d;
  word_t f_q, s_q, f_d, s_d;
  logic  last_q;
  word_t rk_q;
  cnt_t  rd_addr;
  word_t rk_mem [RoundCount];

  logic cfg_key0, cfg_key1;

  assign cfg_key0 = cfg_wr_i && (cfg_index_i == CfgKeyFirst);
  assign cfg_key1 = cfg_wr_i && (cfg_index_i == CfgKeySecond);

  // key schedule step
  assign l_d = word_t'(cnt_q) ^ (k_q + rol(l_q, KeyRotL));
  assign k_d = l_d ^ rol(k_q, KeyKRotL);

  // inverse round
  assign f_d = rol(f_q ^ s_q, RndFRotL);
  assign s_d = rol((rk_q ^ s_q) - f_d, RndSRotL);

  // during rounds fetch the key for the next one down
  assign rd_addr = cmd_i.round_step ? (cnt_q - cnt_t'(1)) : CntLast;

  always_comb begin
    cnt_d = cnt_q;
    priority if (cmd_i.kx_start) begin
      cnt_d = '0;
    end else if (cmd_i.load_in) begin
      cnt_d = CntLast;
    end else if (cmd_i.kx_step) begin
      cnt_d = (cnt_q == CntLast) ? CntLast : (cnt_q + cnt_t'(1));
    end else if (cmd_i.round_step) begin
      cnt_d = cnt_q - cnt_t'(1);
    end
  end

  always_comb begin
    keys_valid_d = keys_valid_q;
    priority if (cfg_key0 || cfg_key1) begin
      keys_valid_d = 1'b0;
    end else if (cmd_i.kx_step && (cnt_q == CntLast)) begin
      keys_valid_d = 1'b1;
    end
  end

  assign out_valid_d = cmd_i.load_out ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q       <= '0;
      key1_q       <= '0;
      keys_valid_q <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_key0) key0_q <= cfg_data_i;
      if (cfg_key1) key1_q <= cfg_data_i;
      keys_valid_q <= keys_valid_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.kx_start) begin
      k_q <= key0_q;
      l_q <= key1_q;
    end else if (cmd_i.kx_step) begin
      k_q <= k_d;
      l_q <= l_d;
    end
    if (cmd_i.load_in) begin
      f_q    <= cipher_first_i;
      s_q    <= cipher_second_i;
      last_q <= last_block_i;
    end else if (cmd_i.round_step) begin
      f_q <= f_d;
      s_q <= s_d;
    end
    if (cmd_i.load_out) begin
      plain_first_o  <= f_q;
      plain_second_o <= s_q;
      last_out_o     <= last_q;
    end
  end

  // round-key memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.kx_step) begin
      rk_mem[cnt_q] <= k_q;
    end
    rk_q <= rk_mem[rd_addr];
  end

  assign out_valid_o         = out_valid_q;
  assign status_o.keys_valid = keys_valid_q;
  assign status_o.cnt_last   = (cnt_q == CntLast);
  assign status_o.cnt_zero   = (cnt_q == '0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

### sv/speck128_block_decrypt.sv
// Speck 128/128 block decryptor, top level.
//
// cipher_i takes one ciphertext item (two 64-bit words and a last-block mark);
// plain_o gives one plaintext item for each, in order, with the mark copied.
// cfg_i writes the key words: index 0 first word, index 1 second word; other
// indexes are ignored. cfg_i is always ready. Writing a key word drops the
// expanded schedule, and the next item first expands 32 round keys into the
// round-key memory, one key a cycle, and then refetches the last key.
// An item then runs one inverse round a cycle from round 31 down to 0, each
// round taking its key from the memory read port; the read is registered and
// fetched one round ahead. A new item is accepted in the cycle after the
// result moves to the output register.
// If the receiver stalls, the result stays in the output register and the
// next item may still be accepted and decrypted; it then waits until the
// output register frees. Reset clears both key words to zero, marks the
// schedule as not expanded and empties the output register.
module speck128_block_decrypt (
  input logic               clk_i,
  input logic               rst_ni,
  spkdec_in_if.sink         cipher_i,
  spkdec_out_if.source      plain_o,
  spkdec_cfg_if.sink        cfg_i
);
  import spkdec_pkg::*;

`include "assert_macros.svh"

  cmd_t    cmd;
  status_t status;
  logic    cfg_wr;
  logic    cfg_key_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;
  assign cfg_key_wr  = cfg_wr && ((cfg_i.index == CfgKeyFirst) ||
                                  (cfg_i.index == CfgKeySecond));

  spkdec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cipher_i.valid),
    .in_ready_o (cipher_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spkdec_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_wr_i        (cfg_wr),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .cipher_first_i  (cipher_i.cipher_first),
    .cipher_second_i (cipher_i.cipher_second),
    .last_block_i    (cipher_i.last_block),
    .out_valid_o     (plain_o.valid),
    .out_ready_i     (plain_o.ready),
    .plain_first_o   (plain_o.plain_first),
    .plain_second_o  (plain_o.plain_second),
    .last_out_o      (plain_o.last_out)
  );

  `SPKD_ASSERT(a_expand_sets_valid, clk_i, rst_ni, (cmd.kx_step && status.cnt_last && !cfg_key_wr) |=> status.keys_valid, "schedule not marked valid after expansion")
  `SPKD_ASSERT(a_key_write_drops, clk_i, rst_ni, cfg_key_wr |=> !status.keys_valid, "key write did not drop the schedule")
  `SPKD_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.load_out && !status.out_free, "waiting result overwritten")
  `SPKD_ASSERT_NEVER(a_accept_idle_only, clk_i, rst_ni, cipher_i.ready && (cmd.round_step || cmd.kx_step), "item accepted while busy")

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the Speck 128/128 block decryptor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spkdec_pkg::*;

  localparam int unsigned Rounds       = 32;
  localparam int unsigned ScheduleRotL = 56;
  localparam int unsigned KeyRotL      = 3;
  localparam int unsigned FirstRotL    = 61;
  localparam int unsigned SecondRotL   = 8;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned RandomItems  = 225;
  localparam int unsigned EdgeItems    = 10;
  localparam int unsigned LongHold     = 600;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned CycleLimit   = 1000000;

  // indexes that decode to no register
  localparam logic [CfgIdxW-1:0] CfgSpare    = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgTopIndex = 8'hff;

  localparam word_t AllOnes = '1;

  typedef struct packed {
    word_t first;
    word_t second;
    logic  last;
  } plain_item_t;

  class plain_scoreboard;
    word_t       key_word [2];
    word_t       round_key [Rounds];
    bit          schedule_ready;
    plain_item_t plain_q [$];
    int unsigned failures;

    function new();
      key_word[0]    = '0;
      key_word[1]    = '0;
      schedule_ready = 1'b0;
      failures       = 0;
    endfunction

    function word_t rotl(word_t v, int unsigned n);
      logic [2*WordW-1:0] both;
      both = {v, v} << n;
      return both[2*WordW-1:WordW];
    endfunction

    function void write_key(logic [CfgIdxW-1:0] idx, word_t data);
      if (idx == CfgKeyFirst) begin
        key_word[0]    = data;
        schedule_ready = 1'b0;
      end else if (idx == CfgKeySecond) begin
        key_word[1]    = data;
        schedule_ready = 1'b0;
      end
    endfunction

    // decrypts one accepted ciphertext item, expanding the schedule first if stale
    function void note_block(word_t f, word_t s, logic last);
      plain_item_t item;
      word_t       k;
      word_t       l;
      if (!schedule_ready) begin
        k = key_word[0];
        l = key_word[1];
        for (int i = 0; i < Rounds; i++) begin
          round_key[i] = k;
          l = word_t'(i) ^ (k + rotl(l, ScheduleRotL));
          k = l ^ rotl(k, KeyRotL);
        end
        schedule_ready = 1'b1;
      end
      for (int i = Rounds - 1; i >= 0; i--) begin
        f = rotl(f ^ s, FirstRotL);
        s = rotl((round_key[i] ^ s) - f, SecondRotL);
      end
      item.first  = f;
      item.second = s;
      item.last   = last;
      plain_q.push_back(item);
    endfunction

    function void check_plain(word_t f, word_t s, logic last);
      plain_item_t want;
      if (plain_q.size() == 0) begin
        $error("plaintext item with none expected: %h %h %b", f, s, last);
        failures++;
        return;
      end
      want = plain_q.pop_front();
      if (f !== want.first) begin
        $error("plain_first: expected %h, got %h", want.first, f);
        failures++;
      end
      if (s !== want.second) begin
        $error("plain_second: expected %h, got %h", want.second, s);
        failures++;
      end
      if (last !== want.last) begin
        $error("last_out: expected %b, got %b", want.last, last);
        failures++;
      end
    endfunction

    function bit idle();
      return plain_q.size() == 0;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  spkdec_in_if  cipher_if ();
  spkdec_out_if plain_if ();
  spkdec_cfg_if cfg_if ();

  speck128_block_decrypt dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cipher_i (cipher_if),
    .plain_o  (plain_if),
    .cfg_i    (cfg_if)
  );

  plain_scoreboard sb = new();

  bit          idle_on = 1'b1;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("speck128_block_decrypt: mismatch");
    $finish;
  end

  // valid is left high so back-to-back items need no second assignment in one step
  task automatic send_block(word_t f, word_t s, logic last);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      cipher_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cipher_if.valid         <= 1'b1;
    cipher_if.cipher_first  <= f;
    cipher_if.cipher_second <= s;
    cipher_if.last_block    <= last;
    do @(posedge clk); while (!cipher_if.ready);
    sb.note_block(f, s, last);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, word_t data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_key(idx, data);
  endtask

  task automatic wait_results();
    do @(posedge clk); while (!sb.idle());
  endtask

  // receiver: random stall before each item while idle_on is set, or a long one on request
  initial begin
    int unsigned stall;
    plain_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 9) : 0;
      end
      if (stall > 0) begin
        plain_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      plain_if.ready <= 1'b1;
      do @(posedge clk); while (!plain_if.valid);
      sb.check_plain(plain_if.plain_first, plain_if.plain_second, plain_if.last_out);
    end
  end

  initial begin
    word_t f;
    word_t s;
    rst_n                   <= 1'b0;
    cipher_if.valid         <= 1'b0;
    cipher_if.cipher_first  <= '0;
    cipher_if.cipher_second <= '0;
    cipher_if.last_block    <= 1'b0;
    cfg_if.valid            <= 1'b0;
    cfg_if.index            <= '0;
    cfg_if.data             <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PhaseCount; p++) begin
      // phase 0 runs on the reset key words
      case (p)
        1: begin
          write_reg(CfgKeyFirst, AllOnes);
          write_reg(CfgKeySecond, AllOnes);
          write_reg(CfgSpare, {$urandom(), $urandom()});
          write_reg(CfgTopIndex, {$urandom(), $urandom()});
        end
        2: begin
          write_reg(CfgKeyFirst, '0);
          write_reg(CfgKeySecond, AllOnes);
        end
        3: write_reg(CfgKeyFirst, AllOnes);
        5: write_reg(CfgKeySecond, {$urandom(), $urandom()});
        6: begin
          f = {$urandom(), $urandom()};
          write_reg(CfgKeyFirst, f);
          write_reg(CfgKeySecond, {$urandom(), $urandom()});
          write_reg(CfgKeyFirst, f);
        end
        default: if (p != 0) begin
          write_reg(CfgKeyFirst, {$urandom(), $urandom()});
          write_reg(CfgKeySecond, {$urandom(), $urandom()});
        end
      endcase
      cfg_if.valid <= 1'b0;
      idle_on = (p != 1) && (p != 4);

      if (p < 2) begin
        for (int n = 0; n < EdgeItems; n++) begin
          case (n)
            0: begin f = '0;                     s = '0;                     end
            1: begin f = AllOnes;                s = AllOnes;                end
            2: begin f = '0;                     s = AllOnes;                end
            3: begin f = AllOnes;                s = '0;                     end
            4: begin f = 64'h5555555555555555;   s = 64'haaaaaaaaaaaaaaaa;   end
            5: begin f = 64'haaaaaaaaaaaaaaaa;   s = 64'h5555555555555555;   end
            6: begin f = 64'h1;                  s = 64'h8000000000000000;   end
            7: begin f = 64'h8000000000000000;   s = 64'h1;                  end
            8: begin f = 64'h0123456789abcdef;   s = 64'hfedcba9876543210;   end
            default: begin f = 64'h7fffffffffffffff; s = 64'h8000000000000000; end
          endcase
          send_block(f, s, n[0]);
        end
      end

      // fill the block against a stalled receiver
      if (p == 2 || p == 5) hold_cycles = LongHold;

      for (int n = 0; n < RandomItems; n++) begin
        if (n == RandomItems / 2) begin
          cipher_if.valid <= 1'b0;
          wait_results();
        end
        send_block({$urandom(), $urandom()}, {$urandom(), $urandom()},
                   1'($urandom_range(0, 1)));
      end
      cipher_if.valid <= 1'b0;
      wait_results();
    end

    repeat (SettleCycles) @(posedge clk);
    if (sb.failures == 0) begin
      $display("speck128_block_decrypt: match");
    end else begin
      $display("speck128_block_decrypt: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/spkdec_pkg.sv
sv/spkdec_in_if.sv
sv/spkdec_out_if.sv
sv/spkdec_cfg_if.sv
sv/spkdec_ctrl.sv
sv/spkdec_dp.sv
sv/speck128_block_decrypt.sv
tb/sv/testbench.sv
